// File: rtl/dll_pkg.sv
// Shared widths, op and status codes for the linked list engine.
package dll_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int OP_W          = 3;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 9;

  typedef enum logic [OP_W-1:0] {
    OP_INS_TAIL = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_FIRST    = 3'd2,
    OP_LAST     = 3'd3,
    OP_NEXT     = 3'd4,
    OP_PREV     = 3'd5,
    OP_REMOVE   = 3'd6,
    OP_NOP      = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_END       = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_CURSOR = 2'd3
  } status_t;

endpackage

// File: rtl/dll_req_if.sv
// Request channel: op code and data word, valid/ready handshake.
interface dll_req_if;
  import dll_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// File: rtl/dll_rsp_if.sv
// Response channel: status, data word read or removed, element count.
interface dll_rsp_if;
  import dll_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

// File: rtl/dll_ram.sv
// One write port, one registered read port node memory.
module dll_ram #(
  parameter int DEPTH = dll_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = dll_pkg::VALUE_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/doubly_linked_list_engine.sv
// Doubly linked list engine with cursor, node pool of DEPTH entries.
// A new request word is accepted only in S_IDLE, once the previous word's response has
//   reached the output register; each word waits on the registered read of the link
//   memories, then on the link write-back steps of the sequencer.
// Reset (synchronous, rst high): empty list, no cursor, empty free stack; node memories
//   are not cleared, only linked nodes are ever read.
module doubly_linked_list_engine #(
  parameter int DEPTH = dll_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  dll_req_if.sink   req,
  dll_rsp_if.source rsp
);
  import dll_pkg::*;

  // Node index width holds the null code DEPTH; memory address width does not.
  localparam int IW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] NULL_IDX = IW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,  // waiting for a request word; link memories read at the current cursor, value prefetched
    S_EXEC,  // link/value reads available, main decision and first writes
    S_LINK,  // insert: patch the old end node's link
    S_READ,  // next/prev: value of the new cursor node available
    S_HOLD   // response waits for the output register to drain
  } state_t;

  state_t state, state_next;

  // Request captured at accept.
  op_t                 op_q, op_q_next;
  logic [VALUE_W-1:0]  value_q, value_q_next;
  logic [IW-1:0]       node, node_next;   // node being inserted or new cursor node

  // List control state.
  logic [IW-1:0] first_node, first_node_next;
  logic [IW-1:0] last_node, last_node_next;
  logic [IW-1:0] cursor, cursor_next;
  logic          before_first, before_first_next;
  logic [IW-1:0] item_count, item_count_next;
  logic [IW-1:0] free_top, free_top_next;
  logic [IW-1:0] fresh_next, fresh_next_next;

  // Output register and parked response.
  logic               out_valid, out_valid_next;
  status_t            out_status, out_status_next;
  logic [VALUE_W-1:0] out_value, out_value_next;
  logic [COUNT_W-1:0] out_count, out_count_next;
  status_t            hold_status, hold_status_next;
  logic [VALUE_W-1:0] hold_value, hold_value_next;

  // Memory ports: next links, prev links, node values, free stack.
  logic               nx_we, pv_we, vl_we, fs_we;
  logic [AW-1:0]      nx_waddr, pv_waddr, vl_waddr, fs_waddr;
  logic [IW-1:0]      nx_wdata, pv_wdata;
  logic [VALUE_W-1:0] vl_wdata;
  logic [AW-1:0]      fs_wdata;
  logic [AW-1:0]      nx_raddr, pv_raddr, vl_raddr, fs_raddr;
  logic [IW-1:0]      nx_rdata, pv_rdata;
  logic [VALUE_W-1:0] vl_rdata;
  logic [AW-1:0]      fs_rdata;

  // Completion of the current request.
  logic               fin;
  status_t            fin_status;
  logic [VALUE_W-1:0] fin_rd;
  logic               out_free;

  dll_ram #(.DEPTH(DEPTH), .WIDTH(IW)) u_next_link (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  dll_ram #(.DEPTH(DEPTH), .WIDTH(IW)) u_prev_link (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata)
  );

  dll_ram #(.DEPTH(DEPTH), .WIDTH(VALUE_W)) u_node_value (
    .clk(clk), .we(vl_we), .waddr(vl_waddr), .wdata(vl_wdata),
    .raddr(vl_raddr), .rdata(vl_rdata)
  );

  dll_ram #(.DEPTH(DEPTH), .WIDTH(AW)) u_free_stack (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.read_value = out_value;
  assign rsp.count      = out_count;

  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    logic [IW-1:0] n_sel;
    logic [IW-1:0] p_sel;

    n_sel = NULL_IDX;
    p_sel = NULL_IDX;

    state_next        = state;
    op_q_next         = op_q;
    value_q_next      = value_q;
    node_next         = node;
    first_node_next   = first_node;
    last_node_next    = last_node;
    cursor_next       = cursor;
    before_first_next = before_first;
    item_count_next   = item_count;
    free_top_next     = free_top;
    fresh_next_next   = fresh_next;
    hold_status_next  = hold_status;
    hold_value_next   = hold_value;

    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_value_next  = out_value;
    out_count_next  = out_count;

    // Reads default to the cursor node and the free stack top, so the
    // word taken in S_IDLE finds its operands ready in S_EXEC.
    nx_raddr = cursor[AW-1:0];
    pv_raddr = cursor[AW-1:0];
    vl_raddr = cursor[AW-1:0];
    fs_raddr = AW'(free_top - IW'(1));

    nx_we = 1'b0;  nx_waddr = '0;  nx_wdata = '0;
    pv_we = 1'b0;  pv_waddr = '0;  pv_wdata = '0;
    vl_we = 1'b0;  vl_waddr = '0;  vl_wdata = '0;
    fs_we = 1'b0;  fs_waddr = '0;  fs_wdata = '0;

    fin        = 1'b0;
    fin_status = ST_OK;
    fin_rd     = '0;

    case (state)
      S_IDLE: begin
        // Prefetch the value a first/last/next-from-before-first will return.
        case (op_t'(req.op))
          OP_FIRST, OP_NEXT: vl_raddr = first_node[AW-1:0];
          OP_LAST:           vl_raddr = last_node[AW-1:0];
          default:           vl_raddr = cursor[AW-1:0];
        endcase
        if (req.valid) begin
          op_q_next    = op_t'(req.op);
          value_q_next = req.value;
          state_next   = S_EXEC;
        end
      end

      S_EXEC: begin
        case (op_q)
          OP_INS_TAIL, OP_INS_HEAD: begin
            if (free_top == '0 && fresh_next == NULL_IDX) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              // Released nodes first, then never-used ones in order.
              if (free_top != '0) begin
                n_sel         = IW'(fs_rdata);
                free_top_next = free_top - IW'(1);
              end else begin
                n_sel           = fresh_next;
                fresh_next_next = fresh_next + IW'(1);
              end
              node_next = n_sel;
              vl_we     = 1'b1;
              vl_waddr  = n_sel[AW-1:0];
              vl_wdata  = value_q;
              nx_we     = 1'b1;
              nx_waddr  = n_sel[AW-1:0];
              nx_wdata  = (op_q == OP_INS_TAIL) ? NULL_IDX : first_node;
              pv_we     = 1'b1;
              pv_waddr  = n_sel[AW-1:0];
              pv_wdata  = (op_q == OP_INS_TAIL) ? last_node : NULL_IDX;
              state_next = S_LINK;
            end
          end

          OP_FIRST, OP_LAST: begin
            n_sel = (op_q == OP_FIRST) ? first_node : last_node;
            fin   = 1'b1;
            if (n_sel < NULL_IDX) begin
              cursor_next       = n_sel;
              before_first_next = 1'b0;
              fin_rd            = vl_rdata;
            end else begin
              fin_status = ST_NO_CURSOR;
            end
          end

          OP_NEXT: begin
            if (before_first) begin
              fin = 1'b1;
              if (first_node < NULL_IDX) begin
                cursor_next       = first_node;
                before_first_next = 1'b0;
                fin_rd            = vl_rdata;
              end else begin
                fin_status = ST_END;
              end
            end else if (cursor < NULL_IDX) begin
              n_sel = nx_rdata;
              if (n_sel < NULL_IDX) begin
                node_next  = n_sel;
                vl_raddr   = n_sel[AW-1:0];
                state_next = S_READ;
              end else begin
                fin        = 1'b1;
                fin_status = ST_END;
              end
            end else begin
              fin        = 1'b1;
              fin_status = ST_NO_CURSOR;
            end
          end

          OP_PREV: begin
            if (before_first) begin
              fin        = 1'b1;
              fin_status = ST_END;
            end else if (cursor < NULL_IDX) begin
              n_sel = pv_rdata;
              if (n_sel < NULL_IDX) begin
                node_next  = n_sel;
                vl_raddr   = n_sel[AW-1:0];
                state_next = S_READ;
              end else begin
                fin        = 1'b1;
                fin_status = ST_END;
              end
            end else begin
              fin        = 1'b1;
              fin_status = ST_NO_CURSOR;
            end
          end

          OP_REMOVE: begin
            fin = 1'b1;
            if (before_first || !(cursor < NULL_IDX)) begin
              fin_status = ST_NO_CURSOR;
            end else begin
              // Unlink: both neighbor patches go to different memories.
              p_sel  = pv_rdata;
              n_sel  = nx_rdata;
              fin_rd = vl_rdata;
              if (p_sel < NULL_IDX) begin
                nx_we    = 1'b1;
                nx_waddr = p_sel[AW-1:0];
                nx_wdata = n_sel;
              end else begin
                first_node_next = n_sel;
              end
              if (n_sel < NULL_IDX) begin
                pv_we    = 1'b1;
                pv_waddr = n_sel[AW-1:0];
                pv_wdata = p_sel;
              end else begin
                last_node_next = p_sel;
              end
              if (free_top < NULL_IDX) begin
                fs_we         = 1'b1;
                fs_waddr      = free_top[AW-1:0];
                fs_wdata      = cursor[AW-1:0];
                free_top_next = free_top + IW'(1);
              end
              if (item_count != '0) begin
                item_count_next = item_count - IW'(1);
              end
              if (p_sel < NULL_IDX) begin
                cursor_next = p_sel;
              end else begin
                cursor_next       = NULL_IDX;
                before_first_next = 1'b1;
              end
            end
          end

          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_LINK: begin
        fin             = 1'b1;
        item_count_next = item_count + IW'(1);
        if (op_q == OP_INS_TAIL) begin
          if (last_node < NULL_IDX) begin
            nx_we    = 1'b1;
            nx_waddr = last_node[AW-1:0];
            nx_wdata = node;
          end else begin
            first_node_next = node;
          end
          last_node_next = node;
        end else begin
          if (first_node < NULL_IDX) begin
            pv_we    = 1'b1;
            pv_waddr = first_node[AW-1:0];
            pv_wdata = node;
          end else begin
            last_node_next = node;
          end
          first_node_next = node;
        end
      end

      S_READ: begin
        fin               = 1'b1;
        cursor_next       = node;
        before_first_next = 1'b0;
        fin_rd            = vl_rdata;
      end

      S_HOLD: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = hold_status;
          out_value_next  = hold_value;
          out_count_next  = COUNT_W'(item_count);
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Hand the response to the output register, or park it if still full.
    if (fin) begin
      if (out_free) begin
        out_valid_next  = 1'b1;
        out_status_next = fin_status;
        out_value_next  = fin_rd;
        out_count_next  = COUNT_W'(item_count_next);
        state_next      = S_IDLE;
      end else begin
        hold_status_next = fin_status;
        hold_value_next  = fin_rd;
        state_next       = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      first_node   <= NULL_IDX;
      last_node    <= NULL_IDX;
      cursor       <= NULL_IDX;
      before_first <= 1'b0;
      item_count   <= '0;
      free_top     <= '0;
      fresh_next   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      first_node   <= first_node_next;
      last_node    <= last_node_next;
      cursor       <= cursor_next;
      before_first <= before_first_next;
      item_count   <= item_count_next;
      free_top     <= free_top_next;
      fresh_next   <= fresh_next_next;
      out_valid    <= out_valid_next;
    end
    op_q        <= op_q_next;
    value_q     <= value_q_next;
    node        <= node_next;
    hold_status <= hold_status_next;
    hold_value  <= hold_value_next;
    out_status  <= out_status_next;
    out_value   <= out_value_next;
    out_count   <= out_count_next;
  end

endmodule

// File: tb/sv/doubly_linked_list_engine_checker.sv
// Checker for the linked list engine: tracks the list, predicts each response word, compares.
module doubly_linked_list_engine_checker #(
  parameter int DEPTH = dll_pkg::DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  dll_req_if   req,
  dll_rsp_if   rsp,
  output int   mismatches,
  output int   checked,
  output int   outstanding,
  output int   peak,
  output int   full_refusals
);
  timeunit 1ns;
  timeprecision 1ps;
  import dll_pkg::*;

  localparam int LINK_W = $clog2(DEPTH + 1);
  localparam int SLOT_W = $clog2(DEPTH);

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [SLOT_W-1:0] slot_t;
  localparam link_t NULL_LINK = link_t'(DEPTH);
  localparam link_t ONE_LINK  = link_t'(1);

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        count;
  } list_result_t;

  // shadow list
  link_t                     fwd_link  [DEPTH];
  link_t                     back_link [DEPTH];
  logic signed [VALUE_W-1:0] node_word [DEPTH];
  slot_t                     free_slots[DEPTH];
  link_t                     head, tail, cursor;
  logic                      before_head;
  logic [COUNT_W-1:0]        length;
  link_t                     free_depth;
  link_t                     fresh_slot;

  list_result_t pending_results[$];

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  // pool index of a link that is known not to be null
  function automatic slot_t slot_of(input link_t l);
    return l[SLOT_W-1:0];
  endfunction

  function automatic void clear_list();
    head        = NULL_LINK;
    tail        = NULL_LINK;
    cursor      = NULL_LINK;
    before_head = 1'b0;
    length      = '0;
    free_depth  = '0;
    fresh_slot  = '0;
  endfunction

  // released nodes first, then never-used ones in order
  function automatic link_t alloc_node();
    if (free_depth != 0) begin
      free_depth = free_depth - ONE_LINK;
      return link_t'(free_slots[slot_of(free_depth)]);
    end
    if (fresh_slot < NULL_LINK) begin
      fresh_slot = fresh_slot + ONE_LINK;
      return fresh_slot - ONE_LINK;
    end
    return NULL_LINK;
  endfunction

  function automatic list_result_t apply_op(input op_t op, input logic signed [VALUE_W-1:0] word);
    list_result_t res;
    link_t        n;
    link_t        p;
    res.status     = ST_OK;
    res.read_value = '0;
    case (op)
      OP_INS_TAIL, OP_INS_HEAD: begin
        n = alloc_node();
        if (n == NULL_LINK) begin
          res.status = ST_FULL;
          full_refusals++;
        end else begin
          node_word[slot_of(n)] = word;
          if (op == OP_INS_TAIL) begin
            fwd_link[slot_of(n)]  = NULL_LINK;
            back_link[slot_of(n)] = tail;
            if (tail != NULL_LINK) fwd_link[slot_of(tail)] = n;
            else head = n;
            tail = n;
          end else begin
            back_link[slot_of(n)] = NULL_LINK;
            fwd_link[slot_of(n)]  = head;
            if (head != NULL_LINK) back_link[slot_of(head)] = n;
            else tail = n;
            head = n;
          end
          length++;
          if (int'(length) > peak) peak = int'(length);
        end
      end
      OP_FIRST, OP_LAST: begin
        n = (op == OP_FIRST) ? head : tail;
        if (n == NULL_LINK) begin
          res.status = ST_NO_CURSOR;
        end else begin
          cursor         = n;
          before_head    = 1'b0;
          res.read_value = node_word[slot_of(n)];
        end
      end
      OP_NEXT: begin
        if (!before_head && cursor == NULL_LINK) begin
          res.status = ST_NO_CURSOR;
        end else begin
          n = before_head ? head : fwd_link[slot_of(cursor)];
          if (n == NULL_LINK) begin
            res.status = ST_END;
          end else begin
            cursor         = n;
            before_head    = 1'b0;
            res.read_value = node_word[slot_of(n)];
          end
        end
      end
      OP_PREV: begin
        if (before_head) begin
          res.status = ST_END;
        end else if (cursor == NULL_LINK) begin
          res.status = ST_NO_CURSOR;
        end else begin
          n = back_link[slot_of(cursor)];
          if (n == NULL_LINK) begin
            res.status = ST_END;
          end else begin
            cursor         = n;
            res.read_value = node_word[slot_of(n)];
          end
        end
      end
      OP_REMOVE: begin
        if (before_head || cursor == NULL_LINK) begin
          res.status = ST_NO_CURSOR;
        end else begin
          res.read_value = node_word[slot_of(cursor)];
          p = back_link[slot_of(cursor)];
          n = fwd_link[slot_of(cursor)];
          if (p != NULL_LINK) fwd_link[slot_of(p)] = n;
          else head = n;
          if (n != NULL_LINK) back_link[slot_of(n)] = p;
          else tail = p;
          if (free_depth < NULL_LINK) begin
            free_slots[slot_of(free_depth)] = slot_of(cursor);
            free_depth                      = free_depth + ONE_LINK;
          end
          if (length != 0) length--;
          // cursor falls back one node, or to before the head
          if (p != NULL_LINK) begin
            cursor = p;
          end else begin
            cursor      = NULL_LINK;
            before_head = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.count = length;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      clear_list();
      pending_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("response word with nothing pending (status %0d value %0d count %0d)",
                                    rsp.status, rsp.read_value, rsp.count));
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (rsp.status !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      checked, rsp.status, want.status));
          if (rsp.read_value !== want.read_value)
            report_mismatch($sformatf("result %0d: read_value %0d, expected %0d",
                                      checked, rsp.read_value, want.read_value));
          if (rsp.count !== want.count)
            report_mismatch($sformatf("result %0d: count %0d, expected %0d",
                                      checked, rsp.count, want.count));
        end
      end
      if (req.valid && req.ready)
        pending_results.push_back(apply_op(op_t'(req.op), req.value));
    end
    outstanding = pending_results.size();
  end

endmodule

// File: tb/sv/doubly_linked_list_engine_tb.sv
// Top of the linked list engine testbench: clock, reset, stimulus, idling and verdict.
module doubly_linked_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dll_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  // random part: fill the pool past full, drain most of it, then churn near the bottom
  localparam int FILL_WORDS   = 300;
  localparam int DRAIN_WORDS  = 420;
  localparam int CHURN_WORDS  = 120;
  // long receiver hold-off lands inside the churn phase, where the sender never idles
  localparam int HOLD_AT      = 24 + FILL_WORDS + DRAIN_WORDS + 30;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int SETTLE       = 20;

  // op mixes for the random phases
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_CHURN} mix_t;

  logic clk;
  logic rst;

  dll_req_if req_ch ();
  dll_rsp_if rsp_ch ();

  int mismatches;
  int checked;
  int outstanding;
  int peak;
  int full_refusals;

  int sent;           // request words accepted, counted by the sender
  int received;       // response words accepted
  int src_idle;       // percent chance of a gap before each request word
  int dst_idle;       // percent chance of ready low on each cycle
  int n_insert, n_move, n_remove, n_other;

  doubly_linked_list_engine #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  doubly_linked_list_engine_checker #(.DEPTH(DEPTH)) checker_i (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .mismatches    (mismatches),
    .checked       (checked),
    .outstanding   (outstanding),
    .peak          (peak),
    .full_refusals (full_refusals)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready) received <= received + 1;
  end

  // Hard stop in case the block hangs.
  initial begin
    #400000;
    $display("doubly_linked_list_engine regression: fail");
    $finish;
  end

  // Receiver: random ready per cycle, plus one long hold-off so the block backs up
  // and has to stall its request side.
  initial begin : sink_side
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && received >= HOLD_AT) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= dst_idle);
    end
  end

  // Offer one request word, with an optional random gap first. Returns at the
  // edge where the word was taken; valid stays high so back-to-back words
  // need no extra step.
  task automatic send_word(input op_t op, input logic signed [VALUE_W-1:0] word);
    while ($urandom_range(0, 99) < src_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= word;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    case (op)
      OP_INS_TAIL, OP_INS_HEAD:          n_insert++;
      OP_FIRST, OP_LAST, OP_NEXT, OP_PREV: n_move++;
      OP_REMOVE:                         n_remove++;
      default:                           n_other++;
    endcase
  endtask

  // Sender pause: drop valid and wait for every outstanding response word.
  task automatic wait_for_results();
    int guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    while (received < sent && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Mostly random words, with the sign and all-ones/zero corners mixed in.
  function automatic logic signed [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t pick_op(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      // nearly all inserts: the pool runs full and later inserts are refused
      MIX_FILL: begin
        if (r < 48) return OP_INS_TAIL;
        if (r < 95) return OP_INS_HEAD;
        if (r < 96) return OP_NEXT;
        if (r < 97) return OP_PREV;
        if (r < 98) return OP_FIRST;
        if (r < 99) return OP_LAST;
        return OP_REMOVE;
      end
      // remove-heavy; a cursor parked at the tail walks back through the list
      MIX_DRAIN: begin
        if (r < 70) return OP_REMOVE;
        if (r < 76) return OP_LAST;
        if (r < 82) return OP_NEXT;
        if (r < 86) return OP_PREV;
        if (r < 88) return OP_FIRST;
        if (r < 92) return OP_INS_TAIL;
        if (r < 96) return OP_INS_HEAD;
        return OP_NOP;
      end
      default: begin
        if (r < 17) return OP_INS_TAIL;
        if (r < 34) return OP_INS_HEAD;
        if (r < 64) return OP_REMOVE;
        if (r < 72) return OP_NEXT;
        if (r < 80) return OP_PREV;
        if (r < 86) return OP_FIRST;
        if (r < 93) return OP_LAST;
        return OP_NOP;
      end
    endcase
  endfunction

  task automatic run_random(input mix_t mix, input int words);
    for (int i = 0; i < words; i++) send_word(pick_op(mix), rand_word());
  endtask

  // Directed corners: empty list, before-head cursor, ends of the list,
  // node reuse after a remove, and the value extremes.
  task automatic run_directed();
    send_word(OP_NEXT,     '0);              // no cursor
    send_word(OP_PREV,     '0);              // no cursor
    send_word(OP_REMOVE,   '0);              // no cursor
    send_word(OP_FIRST,    '0);              // empty list
    send_word(OP_LAST,     '0);              // empty list
    send_word(OP_INS_TAIL, 32'sh7FFF_FFFF);
    send_word(OP_LAST,     '0);
    send_word(OP_REMOVE,   '0);              // only node: cursor goes before head
    send_word(OP_NEXT,     '0);              // before head, list empty
    send_word(OP_PREV,     '0);              // before head
    send_word(OP_REMOVE,   '0);              // before head
    send_word(OP_INS_HEAD, 32'sh8000_0000);  // reuses the freed node
    send_word(OP_INS_TAIL, '0);
    send_word(OP_INS_TAIL, '1);
    send_word(OP_INS_HEAD, 32'sh5555_5555);  // cursor still sits before the new head
    send_word(OP_NEXT,     '0);              // before head -> head
    send_word(OP_PREV,     '0);              // at head
    send_word(OP_LAST,     '0);
    send_word(OP_NEXT,     '0);              // at tail
    send_word(OP_PREV,     '0);
    send_word(OP_REMOVE,   '0);              // middle node
    send_word(OP_NOP,      32'shAAAA_AAAA);
    send_word(OP_FIRST,    '0);
    send_word(OP_REMOVE,   '0);              // head node: cursor goes before head
  endtask

  initial begin : source_side
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.op    <= OP_NOP;
    req_ch.value <= '0;
    src_idle = 8;
    dst_idle = 79;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 1: sender mostly busy, receiver mostly stalled
    run_directed();
    wait_for_results();
    run_random(MIX_FILL, FILL_WORDS);
    wait_for_results();

    // phase 2: roles swapped
    src_idle = 79;
    dst_idle = 8;
    run_random(MIX_DRAIN, DRAIN_WORDS);
    wait_for_results();

    // phase 3: full rate both ways; the receiver hold-off falls in here
    src_idle = 0;
    dst_idle = 0;
    run_random(MIX_CHURN, CHURN_WORDS);
    wait_for_results();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d request words: %0d inserts, %0d cursor moves, %0d removes, %0d no-ops",
             sent, n_insert, n_move, n_remove, n_other);
    $display("%0d results checked; list peaked at %0d of %0d nodes, %0d inserts refused when full",
             checked, peak, DEPTH, full_refusals);
    if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("doubly_linked_list_engine regression: pass");
    end else begin
      $display("doubly_linked_list_engine regression: fail");
    end
    $finish;
  end

endmodule
